@@ rtl/two_queue_page_buffer_table_macros.svh @@
// Assertion macros for the two-queue page buffer table.
// Included by the top level; needs nothing else.
`ifndef TWO_QUEUE_PAGE_BUFFER_TABLE_MACROS_SVH
`define TWO_QUEUE_PAGE_BUFFER_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Condition a implies condition c in the same cycle.
`define TQPB_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tqpb check failed");
// Condition a implies condition c in the next cycle.
`define TQPB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("tqpb check failed");
`else
`define TQPB_ASSERT_SAME(label, clk, rst, a, c)
`define TQPB_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/tqpb_pkg.sv @@
// Shared types and constants of the two-queue page buffer table.
// Used by every module of the block; depends on nothing.
package tqpb_pkg;

  localparam int FRAMES  = 16;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int PAGE_W  = 64;
  localparam int FIX_W   = 8;
  localparam logic [FIX_W-1:0] FIX_MAX = '1;

  localparam logic OP_FIX   = 1'b0;
  localparam logic OP_UNFIX = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISS      = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_BAD_UNFIX = 3'd4
  } status_t;

  typedef logic [FRAME_W-1:0] frame_idx_t;

  typedef struct packed {
    logic              operation;
    logic [PAGE_W-1:0] page_id;
    logic [3:0]        frame_sel;
    logic              mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [3:0]        frame_index;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic              write_back;
  } res_t;

  // Command to one queue: remove the entry holding key, or append key at the tail.
  typedef struct packed {
    logic       remove;
    logic       push;
    frame_idx_t key;
  } qcmd_t;

endpackage

@@ rtl/tqpb_queue_slot.sv @@
// One slot of a frame queue: holds a frame number and shifts toward the head.
// Depends on tqpb_pkg.
module tqpb_queue_slot
  import tqpb_pkg::*;
(
  input  logic             clk,
  input  qcmd_t            cmd,
  input  frame_idx_t       idx,
  input  logic [CNT_W-1:0] length,
  input  logic             shift_in,
  input  frame_idx_t       next_frame,
  output frame_idx_t       frame,
  output logic             shift_out
);

  logic live;
  logic tail;
  logic match;

  // The slot is live below the queue length; the tail slot is the first free one.
  assign live  = CNT_W'(idx) < length;
  assign tail  = CNT_W'(idx) == length;
  assign match = live && (frame == cmd.key);

  // Every slot at or after the removed entry takes its neighbor's frame.
  assign shift_out = shift_in | match;

  always_ff @(posedge clk) begin
    if (cmd.remove && shift_out) begin
      frame <= next_frame;
    end else if (cmd.push && tail) begin
      frame <= cmd.key;
    end
  end

endmodule

@@ rtl/tqpb_queue.sv @@
// Frame queue built as a row of slots with a length counter.
// Depends on tqpb_pkg and tqpb_queue_slot.
module tqpb_queue
  import tqpb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  qcmd_t                   cmd,
  output frame_idx_t [FRAMES-1:0] frames,
  output logic [CNT_W-1:0]        length
);

  logic [FRAMES:0] shift;

  assign shift[0] = 1'b0;

  // Row of slots; the removal mark ripples from the head toward the tail.
  for (genvar k = 0; k < FRAMES; k++) begin : g_slot
    frame_idx_t nxt;
    if (k == FRAMES - 1) begin : g_last
      assign nxt = frames[k];
    end else begin : g_mid
      assign nxt = frames[k + 1];
    end
    tqpb_queue_slot u_slot (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (FRAME_W'(k)),
      .length     (length),
      .shift_in   (shift[k]),
      .next_frame (nxt),
      .frame      (frames[k]),
      .shift_out  (shift[k + 1])
    );
  end

  // The length drops when a live entry matched and grows on an append while not full.
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.remove && shift[FRAMES]) begin
      length <= length - CNT_W'(1);
    end else if (cmd.push && (length < CNT_W'(FRAMES))) begin
      length <= length + CNT_W'(1);
    end
  end

endmodule

@@ rtl/two_queue_page_buffer_table.sv @@
// Two-queue page buffer table. An unfix is settled in the unfix state after accept;
// a fix scans the used frames for its page, then takes a hit step (and an LRU append
// unless its fix count is at the limit) or a miss and a load, first searching the FIFO
// then LRU queue for an unfixed victim if the table is full. One item is in work at a time.
// Synchronous reset empties both queues and clears all fix counts and dirty marks.
// The done strobe lasts one cycle and the receiver cannot stall it.
// Depends on tqpb_pkg, tqpb_queue and the assertion macro header.
`include "two_queue_page_buffer_table_macros.svh"

module two_queue_page_buffer_table
  import tqpb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNFIX,
    S_LOOKUP,
    S_HIT,
    S_LRU_PUSH,
    S_MISS,
    S_VICTIM,
    S_LOAD
  } state_t;

  state_t state;

  // Frame table.
  logic [PAGE_W-1:0] frame_page [FRAMES];
  logic [FIX_W-1:0]  fix_count  [FRAMES];
  logic [FRAMES-1:0] dirty_mark;
  logic [CNT_W-1:0]  frames_in_use;

  // Work registers of the item in progress.
  req_t       req;
  frame_idx_t scan;
  logic       phase_lru;
  frame_idx_t target;

  // Queue interfaces.
  qcmd_t                   fifo_cmd;
  qcmd_t                   lru_cmd;
  frame_idx_t [FRAMES-1:0] fifo_frames;
  frame_idx_t [FRAMES-1:0] lru_frames;
  logic [CNT_W-1:0]        fifo_len;
  logic [CNT_W-1:0]        lru_len;

  frame_idx_t        cand;
  logic              cand_live;
  logic              cand_free;
  frame_idx_t        rd_addr;
  logic [PAGE_W-1:0] page_rd;
  logic              scan_used;
  frame_idx_t        sel;
  logic              sel_ok;
  logic [CNT_W:0]    queued_total;

  tqpb_queue u_fifo (
    .clk    (clk),
    .rst    (rst),
    .cmd    (fifo_cmd),
    .frames (fifo_frames),
    .length (fifo_len)
  );

  tqpb_queue u_lru (
    .clk    (clk),
    .rst    (rst),
    .cmd    (lru_cmd),
    .frames (lru_frames),
    .length (lru_len)
  );

  // Victim candidate at the scan position of the queue being searched.
  assign cand      = phase_lru ? lru_frames[scan] : fifo_frames[scan];
  assign cand_live = CNT_W'(scan) < (phase_lru ? lru_len : fifo_len);
  assign cand_free = cand_live && (fix_count[cand] == '0);

  // Frames are taken lowest first and never released, so the used ones are a prefix.
  assign scan_used = CNT_W'(scan) < frames_in_use;
  assign sel       = req.frame_sel;
  assign sel_ok    = (CNT_W'(sel) < frames_in_use) && (fix_count[sel] != '0);

  // One read port on the page table: lookup scan or victim candidate.
  assign rd_addr = (state == S_LOOKUP) ? scan : cand;
  assign page_rd = frame_page[rd_addr];

  assign queued_total = {1'b0, fifo_len} + {1'b0, lru_len};

  // Queue commands for the current step.
  always_comb begin
    fifo_cmd = '0;
    lru_cmd  = '0;
    case (state)
      S_HIT: begin
        if (fix_count[target] != FIX_MAX) begin
          fifo_cmd.remove = 1'b1;
          fifo_cmd.key    = target;
          lru_cmd.remove  = 1'b1;
          lru_cmd.key     = target;
        end
      end
      S_LRU_PUSH: begin
        lru_cmd.push = 1'b1;
        lru_cmd.key  = target;
      end
      S_VICTIM: begin
        if (cand_free) begin
          if (phase_lru) begin
            lru_cmd.remove = 1'b1;
            lru_cmd.key    = cand;
          end else begin
            fifo_cmd.remove = 1'b1;
            fifo_cmd.key    = cand;
          end
        end
      end
      S_LOAD: begin
        fifo_cmd.push = 1'b1;
        fifo_cmd.key  = target;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, frame table and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      done          <= 1'b0;
      dirty_mark    <= '0;
      frames_in_use <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        fix_count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req       <= request;
            scan      <= '0;
            phase_lru <= 1'b0;
            result    <= '0;
            busy      <= 1'b1;
            state     <= (request.operation == OP_UNFIX) ? S_UNFIX : S_LOOKUP;
          end
        end
        S_UNFIX: begin
          result.frame_index <= 4'(sel);
          if (sel_ok) begin
            fix_count[sel] <= fix_count[sel] - FIX_W'(1);
            if (req.mark_dirty) begin
              dirty_mark[sel] <= 1'b1;
            end
            result.status <= ST_OK;
          end else begin
            result.status <= ST_BAD_UNFIX;
          end
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_LOOKUP: begin
          if (scan_used && (page_rd == req.page_id)) begin
            target <= scan;
            state  <= S_HIT;
          end else if (!scan_used || (scan == FRAME_W'(FRAMES - 1))) begin
            state <= S_MISS;
          end else begin
            scan <= scan + FRAME_W'(1);
          end
        end
        S_HIT: begin
          result.frame_index <= 4'(target);
          if (fix_count[target] == FIX_MAX) begin
            result.status <= ST_OVERFLOW;
            done          <= 1'b1;
            busy          <= 1'b0;
            state         <= S_IDLE;
          end else begin
            fix_count[target] <= fix_count[target] + FIX_W'(1);
            result.status     <= ST_OK;
            state             <= S_LRU_PUSH;
          end
        end
        S_LRU_PUSH: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_MISS: begin
          if (frames_in_use < CNT_W'(FRAMES)) begin
            target        <= frames_in_use[FRAME_W-1:0];
            frames_in_use <= frames_in_use + CNT_W'(1);
            state         <= S_LOAD;
          end else begin
            scan      <= '0;
            phase_lru <= 1'b0;
            state     <= S_VICTIM;
          end
        end
        S_VICTIM: begin
          if (cand_free) begin
            target               <= cand;
            result.evicted_valid <= 1'b1;
            result.evicted_page  <= page_rd;
            result.write_back    <= dirty_mark[cand];
            state                <= S_LOAD;
          end else if (!cand_live || (scan == FRAME_W'(FRAMES - 1))) begin
            if (!phase_lru) begin
              phase_lru <= 1'b1;
              scan      <= '0;
            end else begin
              result.status <= ST_FULL;
              done          <= 1'b1;
              busy          <= 1'b0;
              state         <= S_IDLE;
            end
          end else begin
            scan <= scan + FRAME_W'(1);
          end
        end
        S_LOAD: begin
          frame_page[target] <= req.page_id;
          fix_count[target]  <= FIX_W'(1);
          dirty_mark[target] <= 1'b0;
          result.status      <= ST_MISS;
          result.frame_index <= 4'(target);
          done               <= 1'b1;
          busy               <= 1'b0;
          state              <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only shown once the block is free again.
  `TQPB_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy)
  // An accepted item keeps the block busy in the next cycle with no result yet.
  `TQPB_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  // Between items the two queue lengths add up to the count of used frames.
  `TQPB_ASSERT_SAME(a_queues_cover, clk, rst, !busy, queued_total == {1'b0, frames_in_use})
  // The count of used frames never passes the table size.
  `TQPB_ASSERT_SAME(a_use_bound, clk, rst, 1'b1, frames_in_use <= CNT_W'(FRAMES))

endmodule

@@ sim/two_queue_page_buffer_table_tb.sv @@
// Self-checking testbench for the two-queue page buffer table.
// Drives fix and unfix items, predicts each result or takes a typed one, and compares it field by field.
// Depends on tqpb_pkg and the two_queue_page_buffer_table RTL.
module two_queue_page_buffer_table_tb
  import tqpb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 64;
  localparam int POOL_SIZE    = 24;
  localparam int HAMMER_LEN   = 256;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  res_t result;

  // Expectation attached to the item now on the request bus.
  logic row_typed;
  res_t row_want;

  // Predicted frame table state.
  logic       frame_used [FRAMES];
  logic [63:0] frame_page [FRAMES];
  logic [7:0] fix_cnt    [FRAMES];
  logic       dirty      [FRAMES];
  frame_idx_t fifo_order [$];
  frame_idx_t lru_order  [$];

  res_t pending_results [$];
  int unsigned accepted_items;
  int unsigned errors;
  int unsigned quiet_cycles;
  bit no_gaps;
  int unsigned items_sent;
  logic [63:0] page_pool [POOL_SIZE];
  dir_row_t directed_rows [$];

  two_queue_page_buffer_table u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Position of a frame in a queue, or -1 when absent.
  function automatic int position_of(frame_idx_t q[$], frame_idx_t f);
    int k;
    for (k = 0; k < q.size(); k++) begin
      if (q[k] == f) return k;
    end
    return -1;
  endfunction

  // Position of the first frame with no fixes in a queue, or -1.
  function automatic int first_unfixed(frame_idx_t q[$]);
    int k;
    for (k = 0; k < q.size(); k++) begin
      if (fix_cnt[q[k]] == 8'd0) return k;
    end
    return -1;
  endfunction

  // Applies one item to the predicted table and returns its result.
  function automatic res_t frame_table_apply(req_t r);
    res_t o;
    int f;
    int hit_frame;
    int pos;
    int victim;
    o = '0;
    if (r.operation == OP_UNFIX) begin
      o.frame_index = r.frame_sel;
      if (!frame_used[r.frame_sel] || fix_cnt[r.frame_sel] == 8'd0) begin
        o.status = ST_BAD_UNFIX;
      end else begin
        o.status = ST_OK;
        fix_cnt[r.frame_sel] = fix_cnt[r.frame_sel] - 8'd1;
        if (r.mark_dirty) dirty[r.frame_sel] = 1'b1;
      end
    end else begin
      hit_frame = -1;
      for (f = 0; f < FRAMES; f++) begin
        if (hit_frame < 0 && frame_used[f] && frame_page[f] == r.page_id) hit_frame = f;
      end
      if (hit_frame >= 0) begin
        o.frame_index = 4'(hit_frame);
        if (fix_cnt[hit_frame] == FIX_MAX) begin
          o.status = ST_OVERFLOW;
        end else begin
          // A hit promotes the frame to the hot end of the LRU queue.
          o.status = ST_OK;
          fix_cnt[hit_frame] = fix_cnt[hit_frame] + 8'd1;
          pos = position_of(lru_order, frame_idx_t'(hit_frame));
          if (pos >= 0) begin
            lru_order.delete(pos);
          end else begin
            pos = position_of(fifo_order, frame_idx_t'(hit_frame));
            if (pos >= 0) fifo_order.delete(pos);
          end
          lru_order = {lru_order, frame_idx_t'(hit_frame)};
        end
      end else begin
        // Miss: lowest free frame, else evict from the FIFO queue, then the LRU queue.
        victim = -1;
        for (f = 0; f < FRAMES; f++) begin
          if (victim < 0 && !frame_used[f]) victim = f;
        end
        if (victim < 0) begin
          pos = first_unfixed(fifo_order);
          if (pos >= 0) begin
            victim = fifo_order[pos];
            fifo_order.delete(pos);
          end else begin
            pos = first_unfixed(lru_order);
            if (pos >= 0) begin
              victim = lru_order[pos];
              lru_order.delete(pos);
            end
          end
          if (victim >= 0) begin
            o.evicted_valid = 1'b1;
            o.evicted_page  = frame_page[victim];
            o.write_back    = dirty[victim];
          end
        end
        if (victim < 0) begin
          o.status = ST_FULL;
        end else begin
          o.status = ST_MISS;
          o.frame_index = 4'(victim);
          frame_used[victim] = 1'b1;
          frame_page[victim] = r.page_id;
          fix_cnt[victim] = 8'd1;
          dirty[victim] = 1'b0;
          fifo_order = {fifo_order, frame_idx_t'(victim)};
        end
      end
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compares each result with the oldest expectation and predicts each accepted item.
  always @(posedge clk) begin : scoreboard
    res_t predicted;
    res_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(result.status));
          check_field("frame_index", 64'(want.frame_index), 64'(result.frame_index));
          check_field("evicted_valid", 64'(want.evicted_valid), 64'(result.evicted_valid));
          check_field("evicted_page", want.evicted_page, result.evicted_page);
          check_field("write_back", 64'(want.write_back), 64'(result.write_back));
        end
      end
      if (start && !busy) begin
        predicted = frame_table_apply(request);
        pending_results = {pending_results, (row_typed ? row_want : predicted)};
        accepted_items++;
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item after a random gap and waits until the block takes it.
  task automatic send_item(req_t r, logic typed, res_t want);
    int gap;
    int unsigned seen;
    if (items_sent % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    request   <= r;
    row_typed <= typed;
    row_want  <= want;
    seen = accepted_items;
    do @(negedge clk); while (accepted_items == seen);
    items_sent++;
  endtask

  function automatic dir_row_t mk_row(logic op, logic [63:0] page, logic [3:0] sel,
                                      logic md, status_t st, logic [3:0] fidx,
                                      logic evv, logic [63:0] evp, logic wb);
    dir_row_t d;
    d.req.operation    = op;
    d.req.page_id      = page;
    d.req.frame_sel    = sel;
    d.req.mark_dirty   = md;
    d.typed            = 1'b1;
    d.want.status      = st;
    d.want.frame_index = fidx;
    d.want.evicted_valid = evv;
    d.want.evicted_page  = evp;
    d.want.write_back    = wb;
    return d;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(dir_row_t d);
    directed_rows = {directed_rows, d};
  endfunction

  initial begin : stimulus
    req_t r;
    int i;
    int pick;
    int f;
    int tries;
    int hammer_at;
    int hammer_left;
    int drain_left;
    int hammer_frame;
    int busy_frames [$];

    start      = 1'b0;
    request    = '0;
    row_typed  = 1'b0;
    row_want   = '0;
    rst        = 1'b1;
    accepted_items = 0;
    errors     = 0;
    quiet_cycles = 0;
    items_sent = 0;
    no_gaps    = 1'b0;
    for (f = 0; f < FRAMES; f++) begin
      frame_used[f] = 1'b0;
      frame_page[f] = '0;
      fix_cnt[f]    = '0;
      dirty[f]      = 1'b0;
    end
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) page_pool[i] = {$urandom, $urandom};

    // Directed rows: bad unfixes after reset, misses, a hit, unfixes, filling the
    // table, eviction from each queue with write-back, and a fully fixed table.
    add_row(mk_row(OP_UNFIX, '0, 4'd0, 1'b0, ST_BAD_UNFIX, 4'd0, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_UNFIX, '1, 4'd15, 1'b1, ST_BAD_UNFIX, 4'd15, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_FIX, '0, 4'd15, 1'b1, ST_MISS, 4'd0, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_FIX, '1, 4'd0, 1'b0, ST_MISS, 4'd1, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_FIX, '0, 4'd9, 1'b0, ST_OK, 4'd0, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_UNFIX, '1, 4'd0, 1'b1, ST_OK, 4'd0, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_UNFIX, '0, 4'd0, 1'b0, ST_OK, 4'd0, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_UNFIX, '0, 4'd0, 1'b0, ST_BAD_UNFIX, 4'd0, 1'b0, '0, 1'b0));
    add_row(mk_row(OP_UNFIX, '0, 4'd1, 1'b1, ST_OK, 4'd1, 1'b0, '0, 1'b0));
    for (i = 2; i < FRAMES; i++) begin
      add_row(mk_row(OP_FIX, 64'h0123_4567_89AB_0000 + 64'(i), 4'(i),
                     1'b0, ST_MISS, 4'(i), 1'b0, '0, 1'b0));
    end
    add_row(mk_row(OP_FIX, 64'h8000_0000_0000_0000, 4'd0, 1'b0,
                   ST_MISS, 4'd1, 1'b1, '1, 1'b1));
    add_row(mk_row(OP_FIX, 64'h1, 4'd0, 1'b0, ST_MISS, 4'd0, 1'b1, '0, 1'b1));
    add_row(mk_row(OP_FIX, 64'h2, 4'd0, 1'b0, ST_FULL, 4'd0, 1'b0, '0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    end

    // Random part, mostly well-formed fix and unfix traffic on a small page pool, with
    // one stretch that drives a frame to its fix limit and back.
    hammer_at    = $urandom_range(100, 700);
    hammer_left  = 0;
    drain_left   = 0;
    hammer_frame = 0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      r.operation  = OP_FIX;
      r.page_id    = {$urandom, $urandom};
      r.frame_sel  = 4'($urandom_range(0, 15));
      r.mark_dirty = 1'($urandom_range(0, 1));
      if (i == hammer_at) begin
        tries = 0;
        hammer_frame = $urandom_range(0, FRAMES - 1);
        while (!frame_used[hammer_frame] && tries < 64) begin
          hammer_frame = $urandom_range(0, FRAMES - 1);
          tries++;
        end
        if (frame_used[hammer_frame]) begin
          hammer_left = HAMMER_LEN;
          drain_left  = HAMMER_LEN;
        end
      end
      if (hammer_left > 0) begin
        r.page_id = frame_page[hammer_frame];
        hammer_left--;
      end else if (drain_left > 0) begin
        r.operation = OP_UNFIX;
        r.frame_sel = 4'(hammer_frame);
        drain_left--;
      end else begin
        pick = $urandom_range(0, 99);
        busy_frames.delete();
        for (f = 0; f < FRAMES; f++) begin
          if (frame_used[f] && fix_cnt[f] != 8'd0) busy_frames = {busy_frames, f};
        end
        if (pick < 42) begin
          r.page_id = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 47) begin
          r.operation = OP_FIX;
        end else if (pick < 92 && busy_frames.size() > 0) begin
          r.operation = OP_UNFIX;
          r.frame_sel = 4'(busy_frames[$urandom_range(0, busy_frames.size() - 1)]);
        end else begin
          r.operation = OP_UNFIX;
        end
      end
      send_item(r, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then give a late result time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tqpb_pkg.sv
rtl/tqpb_queue_slot.sv
rtl/tqpb_queue.sv
rtl/two_queue_page_buffer_table.sv
sim/two_queue_page_buffer_table_tb.sv
